### rtl/hcr_pkg.sv
// Shared constants, types and controller commands for the height colour ramp.
package hcr_pkg;

	localparam int HEIGHT_BITS = 32;
	localparam int LEVEL_BITS  = 8;
	localparam int DIV_STEPS   = LEVEL_BITS;
	localparam int CNT_BITS    = $clog2(DIV_STEPS);

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX  = '1;
	localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO = '0;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_COLOUR  = 1'b1;

	typedef logic [HEIGHT_BITS-1:0] ord_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MID   = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIX   = 6'b100000
	} state_t;

	typedef struct packed {
		logic take;
		logic mid;
		logic prep;
		logic check;
		logic step;
		logic load_out;
	} hcr_cmd_t;

endpackage

### rtl/hcr_ctrl.sv
// Controller state machine: sequences one colour word through the datapath.
module hcr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             op,
	output logic             out_valid,
	input  logic             out_stall,
	output hcr_pkg::hcr_cmd_t cmd
);
	import hcr_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.take     = in_valid && (state_q == ST_IDLE);
		cmd.mid      = (state_q == ST_MID);
		cmd.prep     = (state_q == ST_PREP);
		cmd.check    = (state_q == ST_CHECK);
		cmd.step     = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_FIX) && slot_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && op == OP_COLOUR) state_d = ST_MID;
			end
			ST_MID:   state_d = ST_PREP;
			ST_PREP:  state_d = ST_CHECK;
			ST_CHECK: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) state_d = ST_FIX;
			end
			ST_FIX: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// advance the step count through the divide
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/hcr_dp.sv
// Datapath: height extremes, midpoint, span set-up, restoring divider, output word.
module hcr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hcr_pkg::hcr_cmd_t                   cmd,
	input  logic                                op,
	input  logic signed [hcr_pkg::HEIGHT_BITS-1:0] height,
	input  logic                                last,
	output logic [hcr_pkg::LEVEL_BITS-1:0]      red,
	output logic [hcr_pkg::LEVEL_BITS-1:0]      green,
	output logic [hcr_pkg::LEVEL_BITS-1:0]      blue,
	output logic                                last_out
);
	import hcr_pkg::*;

	localparam ord_t SIGN_BIT = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

	ord_t                  lowest_q, highest_q;
	logic                  pass_closed_q;
	ord_t                  z_q, mid_q, num_q, den_q;
	logic                  last_q, lower_q, zero_q, sat_q;
	logic [HEIGHT_BITS:0]  rem_q;
	logic [LEVEL_BITS-1:0] quo_q;
	logic [LEVEL_BITS-1:0] red_q, green_q, blue_q;
	logic                  last_out_q;

	ord_t                  z_in;
	logic [HEIGHT_BITS:0]  sum_w;
	logic                  lower_w;
	ord_t                  base_w, top_w;
	logic [HEIGHT_BITS:0]  num_w, den_w;
	logic                  zero_w;
	logic [HEIGHT_BITS:0]  rem2_w, rem_sub_w;
	logic                  fits_w;
	logic [LEVEL_BITS-1:0] level_w;

	assign z_in  = ord_t'(height) ^ SIGN_BIT;
	assign sum_w = {1'b0, lowest_q} + {1'b0, highest_q};

	assign lower_w = z_q < mid_q;
	assign base_w  = lower_w ? lowest_q : mid_q;
	assign top_w   = lower_w ? mid_q : highest_q;
	assign num_w   = {1'b0, z_q} - {1'b0, base_w};
	assign den_w   = {1'b0, top_w} - {1'b0, base_w};
	assign zero_w  = den_w[HEIGHT_BITS] || (den_w == '0)
		|| (lower_w && (num_w[HEIGHT_BITS] || num_w == '0));

	assign rem2_w    = {rem_q[HEIGHT_BITS-1:0], 1'b0};
	assign rem_sub_w = rem2_w - {1'b0, den_q};
	assign fits_w    = !rem_sub_w[HEIGHT_BITS] || rem2_w[HEIGHT_BITS];

	always_comb begin
		if (zero_q) level_w = LEVEL_ZERO;
		else if (sat_q) level_w = LEVEL_MAX;
		else if (rem_q >= {1'b0, num_q}) level_w = quo_q;
		else level_w = quo_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q      <= '1;
			highest_q     <= '0;
			pass_closed_q <= 1'b1;
		end else if (cmd.take && op == OP_MEASURE) begin
			if (pass_closed_q) begin
				lowest_q  <= z_in;
				highest_q <= z_in;
			end else begin
				if (z_in < lowest_q) lowest_q <= z_in;
				if (z_in > highest_q) highest_q <= z_in;
			end
			pass_closed_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			z_q    <= z_in;
			last_q <= last;
		end
		if (cmd.mid) mid_q <= sum_w[HEIGHT_BITS:1];
		if (cmd.prep) begin
			lower_q <= lower_w;
			num_q   <= num_w[HEIGHT_BITS-1:0];
			den_q   <= den_w[HEIGHT_BITS-1:0];
			zero_q  <= zero_w;
		end
		if (cmd.check) begin
			sat_q <= num_q >= den_q;
			rem_q <= {1'b0, num_q};
			quo_q <= '0;
		end
		if (cmd.step) begin
			rem_q <= fits_w ? rem_sub_w : rem2_w;
			quo_q <= {quo_q[LEVEL_BITS-2:0], fits_w};
		end
		if (cmd.load_out) begin
			last_out_q <= last_q;
			if (lower_q) begin
				red_q   <= LEVEL_ZERO;
				green_q <= level_w;
				blue_q  <= LEVEL_MAX - level_w;
			end else begin
				red_q   <= level_w;
				green_q <= LEVEL_MAX - level_w;
				blue_q  <= LEVEL_ZERO;
			end
		end
	end

	assign red      = red_q;
	assign green    = green_q;
	assign blue     = blue_q;
	assign last_out = last_out_q;

endmodule

### rtl/height_colour_ramp.sv
// Top level of the height colour ramp: controller joined to datapath.
//
// Input channel (in_valid / in_stall) carries op, height (signed Q16.16) and last.
// A measure word (op 0) is taken when idle and folds its height into the running
// minimum and maximum; the first measure word after a closed pass restarts them and
// a measure word with last set closes the pass. It gives no output word.
// A colour word (op 1) runs through midpoint, span set-up, saturation check, an
// eight-step restoring divide and a final correction, and its colour then appears
// on the output channel (out_valid / out_stall). The block takes no new word until
// the colour word has left its final correction step.
// The output register holds a finished word while the receiver stalls; the block
// then takes measure words meanwhile, and a colour word waits in its last step
// until the register frees.
// Reset clears the extremes to most positive minimum and most negative maximum,
// marks the pass closed and empties the output register.
module height_colour_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [hcr_pkg::HEIGHT_BITS-1:0] height,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hcr_pkg::LEVEL_BITS-1:0]      red,
	output logic [hcr_pkg::LEVEL_BITS-1:0]      green,
	output logic [hcr_pkg::LEVEL_BITS-1:0]      blue,
	output logic                                last_out
);
	import hcr_pkg::*;

	hcr_cmd_t cmd;

	hcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	hcr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.op       (op),
		.height   (height),
		.last     (last),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.last_out (last_out)
	);

endmodule

### rtl/hcr_checker.sv
// Port-level checks for the height colour ramp, bound to the top level.
module hcr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                op,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [hcr_pkg::LEVEL_BITS-1:0]      red,
	input logic [hcr_pkg::LEVEL_BITS-1:0]      green,
	input logic [hcr_pkg::LEVEL_BITS-1:0]      blue,
	input logic                                last_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(last_out))
		else $error("stalled output word changed");

	a_measure_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !op |=> !$rose(out_valid))
		else $error("measure word produced an output word");

	a_colour_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op |=> in_stall)
		else $error("colour word did not occupy the block");

	a_rise_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word appeared without work in progress");

	a_two_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red == '0 || blue == '0)
		else $error("red and blue both lit");

endmodule

bind height_colour_ramp hcr_checker u_hcr_checker (.*);

### tb/height_colour_ramp_chk.sv
`timescale 1ns / 100ps
// Checker for the height colour ramp: watches both channels, predicts each colour and compares.
module height_colour_ramp_chk (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic                                   op,
	input  logic signed [hcr_pkg::HEIGHT_BITS-1:0] height,
	input  logic                                   last,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic [hcr_pkg::LEVEL_BITS-1:0]         red,
	input  logic [hcr_pkg::LEVEL_BITS-1:0]         green,
	input  logic [hcr_pkg::LEVEL_BITS-1:0]         blue,
	input  logic                                   last_out,
	output int                                     colours_owed,
	output int                                     mismatches
);
	import hcr_pkg::*;

	localparam ord_t SIGN_BIT = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

	typedef struct packed {
		logic [LEVEL_BITS-1:0] red;
		logic [LEVEL_BITS-1:0] green;
		logic [LEVEL_BITS-1:0] blue;
		logic                  last_out;
	} colour_t;

	ord_t    run_min;
	ord_t    run_max;
	bit      pass_done;
	colour_t pending_colours[$];
	colour_t want;
	int      fail_count;

	// offset binary, so that unsigned order is signed order
	function automatic ord_t to_order(input ord_t raw);
		return raw ^ SIGN_BIT;
	endfunction

	function automatic logic [LEVEL_BITS-1:0] ramp_level(input ord_t num, input ord_t den);
		logic [HEIGHT_BITS+LEVEL_BITS-1:0] scaled;
		if (den == '0)
			return LEVEL_ZERO;
		if (num >= den)
			return LEVEL_MAX;
		scaled = {{LEVEL_BITS{1'b0}}, num};
		scaled = (scaled << LEVEL_BITS) - scaled;
		scaled = scaled / den;
		return scaled[LEVEL_BITS-1:0];
	endfunction

	function automatic colour_t ramp_colour(input ord_t raw, input logic tail);
		ord_t                  z;
		ord_t                  lo;
		ord_t                  hi;
		ord_t                  mid;
		logic [LEVEL_BITS-1:0] level;
		colour_t               c;
		z   = to_order(raw);
		lo  = to_order(run_min);
		hi  = to_order(run_max);
		mid = (lo >> 1) + (hi >> 1) + ord_t'(lo[0] & hi[0]);
		if (z < mid) begin
			level   = (mid <= lo || z <= lo) ? LEVEL_ZERO : ramp_level(z - lo, mid - lo);
			c.red   = LEVEL_ZERO;
			c.green = level;
			c.blue  = LEVEL_MAX - level;
		end else begin
			level   = (hi <= mid) ? LEVEL_ZERO : ramp_level(z - mid, hi - mid);
			c.red   = level;
			c.green = LEVEL_MAX - level;
			c.blue  = LEVEL_ZERO;
		end
		c.last_out = tail;
		return c;
	endfunction

	task automatic check_field(input string name, input logic [LEVEL_BITS-1:0] want_v,
			input logic [LEVEL_BITS-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min      = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
			run_max      = SIGN_BIT;
			pass_done    = 1'b1;
			fail_count   = 0;
			pending_colours.delete();
			colours_owed <= 0;
			mismatches   <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_colours.size() == 0) begin
					$error("colour word with none expected: %0d %0d %0d last %0b",
						red, green, blue, last_out);
					fail_count++;
				end else begin
					want = pending_colours.pop_front();
					check_field("red", want.red, red);
					check_field("green", want.green, green);
					check_field("blue", want.blue, blue);
					check_field("last_out", LEVEL_BITS'(want.last_out), LEVEL_BITS'(last_out));
				end
			end
			if (in_valid && !in_stall) begin
				if (op == OP_MEASURE) begin
					if (pass_done) begin
						run_min   = height;
						run_max   = height;
						pass_done = 1'b0;
					end else begin
						if (to_order(height) < to_order(run_min))
							run_min = height;
						if (to_order(height) > to_order(run_max))
							run_max = height;
					end
					if (last)
						pass_done = 1'b1;
				end else begin
					pending_colours.push_back(ramp_colour(height, last));
				end
			end
			colours_owed <= pending_colours.size();
			mismatches   <= fail_count;
		end
	end

endmodule

### tb/height_colour_ramp_tb.sv
`timescale 1ns / 100ps
// Testbench top for the height colour ramp: clock, reset, measure and colour passes, verdict.
module height_colour_ramp_tb;
	import hcr_pkg::*;

	localparam int     WORDS = 1250;
	localparam longint H_MIN = -(longint'(1) << (HEIGHT_BITS-1));
	localparam longint H_MAX = (longint'(1) << (HEIGHT_BITS-1)) - 1;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          op;
	logic signed [HEIGHT_BITS-1:0] height;
	logic                          last;
	logic                          out_valid;
	logic                          out_stall;
	logic [LEVEL_BITS-1:0]         red;
	logic [LEVEL_BITS-1:0]         green;
	logic [LEVEL_BITS-1:0]         blue;
	logic                          last_out;
	int                            colours_owed;
	int                            mismatches;
	int                            words_sent = 0;
	bit                            hold_request = 1'b0;
	bit                            calm = 1'b0;

	height_colour_ramp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.height    (height),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last_out  (last_out)
	);

	height_colour_ramp_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.height       (height),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_out     (last_out),
		.colours_owed (colours_owed),
		.mismatches   (mismatches)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic signed [HEIGHT_BITS-1:0] fit(input longint v);
		if (v < H_MIN)
			v = H_MIN;
		if (v > H_MAX)
			v = H_MAX;
		return v[HEIGHT_BITS-1:0];
	endfunction

	function automatic longint pick(input longint lo, input longint hi);
		longint unsigned r;
		r = {$urandom, $urandom};
		return lo + longint'(r % longint'(hi - lo + 1));
	endfunction

	function automatic longint colour_height(input longint lo, input longint hi);
		longint mid;
		mid = (lo + hi) >>> 1;
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return mid;
			3: return mid - 1;
			4: return mid + 1;
			5: return lo - $urandom_range(1, 1000);
			6: return hi + $urandom_range(1, 1000);
			7: return pick(H_MIN, H_MAX);
			default: return pick(lo, hi);
		endcase
	endfunction

	task automatic pick_range(output longint lo, output longint hi);
		longint span;
		case ($urandom_range(0, 6))
			0: span = 0;
			1: span = $urandom_range(1, 3);
			2: span = $urandom_range(4, 255);
			3: span = $urandom_range(256, 1 << 20);
			4: begin
				lo = H_MIN;
				hi = H_MAX;
				return;
			end
			default: begin
				lo = pick(H_MIN, H_MAX);
				hi = pick(lo, H_MAX);
				return;
			end
		endcase
		lo = pick(H_MIN, H_MAX - span);
		hi = lo + span;
	endtask

	// hold the word until taken; idle before it at random
	task automatic put_word(input logic o, input logic signed [HEIGHT_BITS-1:0] h, input logic l);
		if (!calm && (words_sent / 50) % 3 != 1 && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		height   <= h;
		last     <= l;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic measure_pass(input longint lo, input longint hi, input int n, input bit closing);
		int at_lo;
		int at_hi;
		at_lo = $urandom_range(0, n - 1);
		at_hi = $urandom_range(0, n - 1);
		if (n > 1 && at_hi == at_lo)
			at_hi = (at_lo + 1) % n;
		for (int i = 0; i < n; i++)
			put_word(OP_MEASURE, fit(i == at_lo ? lo : (i == at_hi ? hi : pick(lo, hi))),
				closing && i == n - 1);
	endtask

	task automatic colour_pass(input longint lo, input longint hi, input int m);
		for (int i = 0; i < m; i++)
			put_word(OP_COLOUR, fit(colour_height(lo, hi)), i == m - 1 || $urandom_range(0, 7) == 0);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (colours_owed == 0);
		@(posedge clk);
	endtask

	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_request = 1'b0;
				out_stall <= 1'b0;
			end else if (!calm && (words_sent / 40) % 3 != 0 && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		longint lo;
		longint hi;
		bit     hold_done;
		bit     drain_done;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		op       <= OP_MEASURE;
		height   <= '0;
		last     <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// colour before any measurement
		put_word(OP_COLOUR, fit(H_MIN), 1'b0);
		put_word(OP_COLOUR, fit(H_MAX), 1'b1);
		put_word(OP_COLOUR, fit(0), 1'b0);
		// full range extremes
		put_word(OP_MEASURE, fit(H_MAX), 1'b0);
		put_word(OP_MEASURE, fit(H_MIN), 1'b0);
		put_word(OP_MEASURE, fit(0), 1'b1);
		put_word(OP_COLOUR, fit(H_MIN), 1'b0);
		put_word(OP_COLOUR, fit(H_MAX), 1'b0);
		put_word(OP_COLOUR, fit(-1), 1'b0);
		put_word(OP_COLOUR, fit(-2), 1'b0);
		put_word(OP_COLOUR, fit(0), 1'b0);
		put_word(OP_COLOUR, fit(1), 1'b1);
		// zero span
		put_word(OP_MEASURE, fit(1000), 1'b1);
		put_word(OP_COLOUR, fit(1000), 1'b0);
		put_word(OP_COLOUR, fit(999), 1'b0);
		put_word(OP_COLOUR, fit(1001), 1'b1);
		// colour inside an open pass, then one-step spans
		put_word(OP_MEASURE, fit(5), 1'b0);
		put_word(OP_COLOUR, fit(5), 1'b0);
		put_word(OP_MEASURE, fit(7), 1'b1);
		put_word(OP_COLOUR, fit(6), 1'b0);
		put_word(OP_COLOUR, fit(7), 1'b0);
		put_word(OP_COLOUR, fit(5), 1'b1);
		// restart after each closed pass
		put_word(OP_MEASURE, fit(-3), 1'b1);
		put_word(OP_MEASURE, fit(9), 1'b1);
		put_word(OP_COLOUR, fit(9), 1'b1);

		while (words_sent < WORDS) begin
			if (!hold_done && words_sent >= 300) begin
				hold_done    = 1'b1;
				hold_request = 1'b1;
			end
			if (!drain_done && words_sent >= 700) begin
				drain_done = 1'b1;
				drain();
			end
			if (words_sent >= WORDS - 200)
				calm = 1'b1;
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(1, 6))
						put_word(1'($urandom_range(0, 1)), fit(pick(H_MIN, H_MAX)),
							$urandom_range(0, 3) == 0);
				end
				2: begin
					pick_range(lo, hi);
					measure_pass(lo, hi, $urandom_range(1, 6), 1'b0);
					colour_pass(lo, hi, $urandom_range(1, 6));
				end
				default: begin
					pick_range(lo, hi);
					measure_pass(lo, hi, $urandom_range(1, 8), 1'b1);
					colour_pass(lo, hi, $urandom_range(1, 10));
				end
			endcase
		end

		drain();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && colours_owed == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
